// ===== sv/dapt_pkg.sv =====
// Shared types and constants for the alarm pending tracker.
package dapt_pkg;

    localparam int ID_W  = 5;
    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        KIND_RAISE  = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_CLEAR  = 2'd3
    } dapt_kind_t;

    typedef struct packed {
        logic             wr_en;
        logic             shift_en;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] fill;
    } dapt_ctrl_t;

endpackage

// ===== sv/dapt_if.sv =====
// Valid/ready channel interfaces for commands, results and configuration.
interface dapt_cmd_if;
    import dapt_pkg::*;
    logic            valid;
    logic            ready;
    logic [1:0]      kind;
    logic [ID_W-1:0] alarm_id;
    modport source (output valid, output kind, output alarm_id, input ready);
    modport sink (input valid, input kind, input alarm_id, output ready);
endinterface

interface dapt_res_if;
    import dapt_pkg::*;
    logic             valid;
    logic             ready;
    logic             added;
    logic             top_valid;
    logic [ID_W-1:0]  top_id;
    logic [CNT_W-1:0] pending_count;
    logic [CNT_W-1:0] processed_count;
    modport source (output valid, output added, output top_valid, output top_id,
                    output pending_count, output processed_count, input ready);
    modport sink (input valid, input added, input top_valid, input top_id,
                  input pending_count, input processed_count, output ready);
endinterface

interface dapt_cfg_if;
    logic valid;
    logic ready;
    logic clear_enable;
    modport source (output valid, output clear_enable, input ready);
    modport sink (input valid, input clear_enable, output ready);
endinterface

// ===== sv/dapt_cell.sv =====
// One slot of the pending list: holds an identifier and shifts left on removal.
module dapt_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  dapt_pkg::dapt_ctrl_t      ctrl,
    input  logic                      shift_in,
    input  logic [dapt_pkg::ID_W-1:0] right_slot,
    output logic [dapt_pkg::ID_W-1:0] slot,
    output logic                      match,
    output logic                      shift_out,
    output logic [dapt_pkg::ID_W-1:0] top_part
);
    import dapt_pkg::*;

    logic [ID_W-1:0] slot_reg;
    logic [ID_W-1:0] slot_next;
    logic            active;
    logic            is_top;
    logic            is_tail;

    always_comb
    begin
        active    = (IDX < int'(ctrl.fill));
        is_top    = ((IDX + 1) == int'(ctrl.fill));
        is_tail   = (IDX == int'(ctrl.fill));
        match     = active && (slot_reg == ctrl.id);
        shift_out = shift_in || match;
        top_part  = is_top ? slot_reg : '0;
        slot_next = slot_reg;
        if (ctrl.wr_en && is_tail)
        begin
            slot_next = ctrl.id;
        end
        else if (ctrl.shift_en && shift_out)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== sv/dedup_alarm_pending_tracker.sv =====
// Top level of the alarm pending tracker with its row of list cells.
// A new command transaction is accepted only once the result of the previous one is being
// formed; the cell row updates first and the result is then formed from the updated row,
// held back while the result channel stalls.
// Reset: pending list and processed set empty, clear_enable set to 1; slot contents are
// left unset and only slots below the fill count are ever read.
module dedup_alarm_pending_tracker #(
    parameter int NUM_ALARMS = 32
) (
    input logic       clk,
    input logic       rst_n,
    dapt_cmd_if.sink  cmd,
    dapt_cfg_if.sink  cfg,
    dapt_res_if.source res
);
    import dapt_pkg::*;

    logic                  cmd_valid_reg, cmd_valid_next;
    logic                  report_reg, report_next;
    logic                  out_valid_reg, out_valid_next;
    dapt_kind_t            kind_reg;
    logic [ID_W-1:0]       id_reg;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]      proc_cnt_reg, proc_cnt_next;
    logic [NUM_ALARMS-1:0] map_reg, map_next;
    logic                  clear_enable_reg;
    logic                  added_reg, added_next;

    logic                  out_added_reg;
    logic                  out_top_valid_reg;
    logic [ID_W-1:0]       out_top_id_reg;
    logic [CNT_W-1:0]      out_pending_reg;
    logic [CNT_W-1:0]      out_processed_reg;

    logic [ID_W-1:0]       slot_vec [NUM_ALARMS];
    logic [ID_W-1:0]       top_vec  [NUM_ALARMS];
    logic [NUM_ALARMS:0]   shift_chain;
    logic [NUM_ALARMS-1:0] match_vec;
    logic [NUM_ALARMS-1:0] id_hot;
    logic [NUM_ALARMS-1:0] top_hot;
    logic [ID_W-1:0]       top_id;
    logic                  in_range;
    logic                  found;
    logic                  map_hit;
    logic                  do_add;
    logic                  report_go;
    logic                  accept;
    dapt_ctrl_t            ctrl;

    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < NUM_ALARMS; i++)
    begin : g_cell
        logic [ID_W-1:0] right_slot;
        if (i == NUM_ALARMS - 1)
        begin : g_last
            assign right_slot = '0;
        end
        else
        begin : g_mid
            assign right_slot = slot_vec[i+1];
        end
        dapt_cell #(.IDX(i)) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .shift_in   (shift_chain[i]),
            .right_slot (right_slot),
            .slot       (slot_vec[i]),
            .match      (match_vec[i]),
            .shift_out  (shift_chain[i+1]),
            .top_part   (top_vec[i])
        );
    end

    always_comb
    begin
        top_id = '0;
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            top_id  = top_id | top_vec[k];
            id_hot[k]  = (k == int'(id_reg));
        end
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            top_hot[k] = (k == int'(top_id));
        end
    end

    always_comb
    begin
        in_range  = (int'(id_reg) < NUM_ALARMS);
        found     = |match_vec;
        map_hit   = |(map_reg & id_hot);
        do_add    = cmd_valid_reg && (kind_reg == KIND_RAISE) && in_range && !found
                    && !map_hit && (int'(fill_reg) < NUM_ALARMS);

        ctrl.wr_en    = do_add;
        ctrl.shift_en = cmd_valid_reg && (kind_reg == KIND_REMOVE) && in_range;
        ctrl.id       = id_reg;
        ctrl.fill     = fill_reg;

        report_go = report_reg && (!out_valid_reg || res.ready);
        accept    = cmd.valid && cmd.ready;

        fill_next     = fill_reg;
        proc_cnt_next = proc_cnt_reg;
        map_next      = map_reg;
        added_next    = added_reg;

        if (cmd_valid_reg)
        begin
            added_next = do_add;
            case (kind_reg)
                KIND_RAISE:
                begin
                    if (do_add)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                KIND_REMOVE:
                begin
                    if (in_range)
                    begin
                        fill_next = fill_reg - CNT_W'(found);
                        map_next  = map_reg & ~id_hot;
                        if (map_hit)
                        begin
                            proc_cnt_next = proc_cnt_reg - CNT_W'(1);
                        end
                    end
                end
                KIND_DONE:
                begin
                    if (fill_reg != '0)
                    begin
                        fill_next     = fill_reg - CNT_W'(1);
                        map_next      = map_reg | top_hot;
                        proc_cnt_next = proc_cnt_reg + CNT_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    if (clear_enable_reg)
                    begin
                        map_next      = '0;
                        proc_cnt_next = '0;
                    end
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end

        cmd_valid_next = accept ? 1'b1 : 1'b0;
        report_next    = cmd_valid_reg ? 1'b1 : (report_go ? 1'b0 : report_reg);
        out_valid_next = report_go ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    assign cmd.ready = !cmd_valid_reg && (!report_reg || report_go);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            report_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            fill_reg         <= '0;
            proc_cnt_reg     <= '0;
            map_reg          <= '0;
            clear_enable_reg <= 1'b1;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            proc_cnt_reg  <= proc_cnt_next;
            map_reg       <= map_next;
            if (cfg.valid && cfg.ready)
            begin
                clear_enable_reg <= cfg.clear_enable;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        added_reg <= added_next;
        if (accept)
        begin
            kind_reg <= dapt_kind_t'(cmd.kind);
            id_reg   <= cmd.alarm_id;
        end
        if (report_go)
        begin
            out_added_reg     <= added_reg;
            out_top_valid_reg <= (fill_reg != '0);
            out_top_id_reg    <= top_id;
            out_pending_reg   <= fill_reg;
            out_processed_reg <= proc_cnt_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.added           = out_added_reg;
    assign res.top_valid       = out_top_valid_reg;
    assign res.top_id          = out_top_id_reg;
    assign res.pending_count   = out_pending_reg;
    assign res.processed_count = out_processed_reg;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the alarm pending tracker with random traffic and stalls.
module tb_top;
    import dapt_pkg::*;

    localparam int N_ALARMS    = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        dapt_kind_t      kind;
        logic [ID_W-1:0] id;
    } alarm_cmd_t;

    typedef struct packed {
        logic             added;
        logic             top_valid;
        logic [ID_W-1:0]  top_id;
        logic [CNT_W-1:0] pending_count;
        logic [CNT_W-1:0] processed_count;
    } alarm_status_t;

    logic clk = 1'b0;
    logic rst_n;

    dapt_cmd_if cmd_bus ();
    dapt_cfg_if cfg_bus ();
    dapt_res_if res_bus ();

    dedup_alarm_pending_tracker #(
        .NUM_ALARMS(N_ALARMS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus),
        .cfg  (cfg_bus),
        .res  (res_bus)
    );

    alarm_cmd_t      cmd_q[$];
    alarm_status_t   status_q[$];
    logic [ID_W-1:0] pend_list[$];
    logic [N_ALARMS-1:0] proc_map = '0;
    logic            clear_en_model = 1'b1;

    logic bursty;
    logic hold_go;
    logic hold_used;
    int   send_gap;
    int   stall_left;
    int   items_queued = 0;
    int   results_seen = 0;
    int   errors = 0;
    int   cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic alarm_status_t apply_command(input dapt_kind_t k,
                                                    input logic [ID_W-1:0] id);
        alarm_status_t s;
        logic hit;
        s = '0;
        case (k)
            KIND_RAISE:
            begin
                hit = proc_map[id];
                foreach (pend_list[i])
                begin
                    if (pend_list[i] == id)
                    begin
                        hit = 1'b1;
                    end
                end
                if (int'(id) < N_ALARMS && !hit && pend_list.size() < N_ALARMS)
                begin
                    pend_list = {pend_list, id};
                    s.added = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (int'(id) < N_ALARMS)
                begin
                    for (int i = pend_list.size() - 1; i >= 0; i--)
                    begin
                        if (pend_list[i] == id)
                        begin
                            pend_list.delete(i);
                        end
                    end
                    proc_map[id] = 1'b0;
                end
            end
            KIND_DONE:
            begin
                if (pend_list.size() > 0)
                begin
                    proc_map[pend_list[$]] = 1'b1;
                    void'(pend_list.pop_back());
                end
            end
            KIND_CLEAR:
            begin
                if (clear_en_model)
                begin
                    proc_map = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (pend_list.size() > 0)
        begin
            s.top_valid = 1'b1;
            s.top_id    = pend_list[$];
        end
        s.pending_count   = CNT_W'(pend_list.size());
        s.processed_count = CNT_W'($countones(proc_map));
        return s;
    endfunction

    task automatic push_item(input dapt_kind_t k, input int id);
        alarm_cmd_t it;
        it.kind = k;
        it.id   = ID_W'(id);
        cmd_q = {cmd_q, it};
        items_queued++;
    endtask

    task automatic gen_random(input int n);
        int start;
        int pick;
        int roll;
        int tmp;
        int order[N_ALARMS];
        dapt_kind_t k;
        start = items_queued;
        while (items_queued - start < n)
        begin
            pick = int'($urandom_range(0, 4));
            if (pick == 4)
            begin
                for (int j = 0; j < N_ALARMS; j++)
                begin
                    order[j] = j;
                end
                for (int j = N_ALARMS - 1; j > 0; j--)
                begin
                    roll = int'($urandom_range(0, j));
                    tmp = order[j];
                    order[j] = order[roll];
                    order[roll] = tmp;
                end
                for (int j = 0; j < N_ALARMS; j++)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        push_item(KIND_REMOVE, order[j]);
                    end
                    push_item(KIND_RAISE, order[j]);
                end
            end
            else
            begin
                repeat ($urandom_range(5, 40))
                begin
                    roll = int'($urandom_range(0, 99));
                    case (pick)
                        0: k = (roll < 80) ? KIND_RAISE : KIND_DONE;
                        1: k = (roll < 55) ? KIND_DONE : ((roll < 80) ? KIND_REMOVE : KIND_RAISE);
                        2: k = dapt_kind_t'(roll[1:0]);
                        default:
                        begin
                            if (roll < 40)
                            begin
                                k = KIND_RAISE;
                            end
                            else if (roll < 70)
                            begin
                                k = KIND_REMOVE;
                            end
                            else if (roll < 85)
                            begin
                                k = KIND_CLEAR;
                            end
                            else
                            begin
                                k = KIND_DONE;
                            end
                        end
                    endcase
                    push_item(k, int'($urandom_range(0, N_ALARMS - 1)));
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (results_seen != items_queued);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_clear_enable(input logic en);
        @(posedge clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.clear_enable <= en;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        cfg_bus.valid  <= 1'b0;
        clear_en_model = en;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        logic       next_valid;
        alarm_cmd_t item;
        if (!rst_n)
        begin
            cmd_bus.valid    <= 1'b0;
            cmd_bus.kind     <= KIND_RAISE;
            cmd_bus.alarm_id <= '0;
            send_gap         <= 0;
        end
        else
        begin
            next_valid = cmd_bus.valid;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                status_q = {status_q,
                            apply_command(dapt_kind_t'(cmd_bus.kind), cmd_bus.alarm_id)};
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                end
                else if (cmd_q.size() > 0)
                begin
                    item = cmd_q.pop_front();
                    next_valid = 1'b1;
                    cmd_bus.kind     <= item.kind;
                    cmd_bus.alarm_id <= item.id;
                    if (bursty && $urandom_range(0, 3) == 0)
                    begin
                        send_gap <= int'($urandom_range(1, 10));
                    end
                end
            end
            cmd_bus.valid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : res_receiver
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            stall_left    <= 0;
            hold_used     <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used     <= 1'b1;
            stall_left    <= HOLD_CYCLES;
            res_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            res_bus.ready <= 1'b0;
        end
        else if (bursty && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= int'($urandom_range(0, 9));
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : res_monitor
        alarm_status_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            results_seen <= results_seen + 1;
            if (status_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Unexpected result transaction: top_id %0d, pending_count %0d",
                             res_bus.top_id, res_bus.pending_count);
                end
            end
            else
            begin
                want = status_q.pop_front();
                check_field("added", int'(want.added), int'(res_bus.added));
                check_field("top_valid", int'(want.top_valid), int'(res_bus.top_valid));
                check_field("top_id", int'(want.top_id), int'(res_bus.top_id));
                check_field("pending_count", int'(want.pending_count),
                            int'(res_bus.pending_count));
                check_field("processed_count", int'(want.processed_count),
                            int'(res_bus.processed_count));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cfg_bus.valid        <= 1'b0;
        cfg_bus.clear_enable <= 1'b1;
        bursty  <= 1'b1;
        hold_go <= 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The register keeps its reset value of 1 for this first part.
        push_item(KIND_DONE, 0);
        push_item(KIND_CLEAR, 0);
        push_item(KIND_REMOVE, 7);
        push_item(KIND_RAISE, 0);
        push_item(KIND_RAISE, 31);
        push_item(KIND_RAISE, 0);
        push_item(KIND_RAISE, 15);
        push_item(KIND_DONE, 3);
        push_item(KIND_RAISE, 15);
        push_item(KIND_REMOVE, 0);
        push_item(KIND_RAISE, 5);
        push_item(KIND_RAISE, 9);
        push_item(KIND_REMOVE, 5);
        push_item(KIND_DONE, 0);
        push_item(KIND_DONE, 0);
        push_item(KIND_REMOVE, 9);
        push_item(KIND_CLEAR, 31);
        push_item(KIND_RAISE, 31);
        push_item(KIND_DONE, 0);
        wait_idle();

        write_clear_enable(1'b0);
        push_item(KIND_CLEAR, 0);
        push_item(KIND_RAISE, 31);
        push_item(KIND_REMOVE, 31);
        push_item(KIND_RAISE, 31);
        push_item(KIND_DONE, 0);
        push_item(KIND_CLEAR, 0);
        gen_random(300);
        wait_idle();

        write_clear_enable(1'b1);
        hold_go <= 1'b1;
        gen_random(300);
        wait_idle();

        write_clear_enable(1'b0);
        gen_random(200);
        wait_idle();

        write_clear_enable(1'b1);
        bursty <= 1'b0;
        gen_random(200);
        wait_idle();
        repeat (10) @(posedge clk);

        if (errors == 0 && status_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dapt_pkg.sv
sv/dapt_if.sv
sv/dapt_cell.sv
sv/dedup_alarm_pending_tracker.sv
dv/tb_top.sv
